@@ rtl/led_eff_pkg.sv @@
// Shared types and constants for the LED effect sequencer.
// Used by the top level, the sequencer datapath and the port checker.
package led_eff_pkg;

  localparam int LED_COUNT = 5;

  typedef logic [LED_COUNT-1:0][7:0] led_vec_t;

  typedef enum logic [3:0] {
    MODE_TICK      = 4'd0,
    MODE_OCTAVE    = 4'd1,
    MODE_BAR       = 4'd2,
    MODE_INVBAR    = 4'd3,
    MODE_STATIC    = 4'd4,
    MODE_VALID     = 4'd5,
    MODE_CHASE     = 4'd6,
    MODE_XFADE     = 4'd7,
    MODE_WIPE      = 4'd8,
    MODE_CAL_ENTER = 4'd9,
    MODE_CAL_EXIT  = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    BG_BREATHE = 2'd0,
    BG_STATIC  = 2'd1,
    BG_NONE    = 2'd2
  } bg_kind_t;

  typedef enum logic [2:0] {
    FX_NONE   = 3'd0,
    FX_VALID  = 3'd1,
    FX_CHASE  = 3'd2,
    FX_BAR    = 3'd3,
    FX_INVBAR = 3'd4,
    FX_XFADE  = 3'd5,
    FX_WIPE   = 3'd6
  } fx_t;

  typedef enum logic [2:0] {
    JOB_BREATHE = 3'd0,
    JOB_BLINK   = 3'd1,
    JOB_XFADE   = 3'd2,
    JOB_VALID   = 3'd3,
    JOB_CHASE   = 3'd4,
    JOB_WIPE    = 3'd5
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_START = 4'd1,
    S_EVAL  = 4'd2,
    S_BG    = 4'd3,
    S_DIV1  = 4'd4,
    S_DIV2  = 4'd5,
    S_SINE  = 4'd6,
    S_MUL1  = 4'd7,
    S_MUL2  = 4'd8,
    S_EMIT  = 4'd9
  } seq_state_t;

  typedef enum logic [2:0] {
    CFG_MIN_VISIBLE   = 3'd0,
    CFG_BAR_EXPIRY    = 3'd1,
    CFG_BAR_RENDER    = 3'd2,
    CFG_BLINK_PERIOD  = 3'd3,
    CFG_BREATHE_FLOOR = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] MIN_VISIBLE_RST    = 16'd150;
  localparam logic [15:0] BAR_EXPIRY_RST     = 16'd1000;
  localparam logic [15:0] BAR_RENDER_RST     = 16'd30;
  localparam logic [15:0] BLINK_PERIOD_RST   = 16'd150;
  localparam logic [15:0] BREATHE_PERIOD_RST = 16'd2000;
  localparam logic [2:0]  OCTAVE_LED_RST     = 3'd2;
  localparam logic [7:0]  LEVEL_FULL         = 8'd255;
  localparam logic [6:0]  PCT_MAX            = 7'd100;

  // Bargraph LED brightness: full when the level covers the LED, partial
  // r*255/100 inside it (reciprocal multiply, exact for r below 100).
  function automatic logic [7:0] bar_led(input logic [6:0] pct, input logic [2:0] idx);
    logic [8:0]  lit;
    logic [8:0]  base;
    logic [6:0]  rr;
    logic [30:0] scaled;
    logic [7:0]  res;
    lit    = 9'(pct) * 9'd5;
    base   = 9'(idx) * 9'd100;
    rr     = '0;
    scaled = '0;
    res    = '0;
    if (lit >= base + 9'd100) begin
      res = LEVEL_FULL;
    end else if (lit > base) begin
      rr     = 7'(lit - base);
      scaled = 31'(rr) * 31'd10695720;
      res    = scaled[29:22];
    end
    return res;
  endfunction

endpackage

@@ rtl/led_eff_div.sv @@
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. Stand-alone; no package dependency.
module led_eff_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);

  localparam int DIV_BITS = 32;
  localparam int CNT_W    = $clog2(DIV_BITS + 1);

  logic [31:0]      quot_r, quot_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [16:0]      trial;
  logic [16:0]      diff;
  logic             ge;

  assign trial = {rem_r, quot_r[31]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[30:0], ge};
      rem_nxt  = ge ? diff[15:0] : trial[15:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ rtl/led_eff_sine.sv @@
// Q1.15 sine ROM, SINE_DEPTH entries over one full turn, registered read.
// Entries are built at elaboration from an odd polynomial on the quarter wave.
module led_eff_sine #(
  parameter int SINE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic [$clog2(SINE_DEPTH)-1:0] addr,
  output logic signed [15:0]            data
);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic        neg;
    n   = 64'(SINE_DEPTH);
    u   = 64'(k) * 64'd4;
    neg = 1'b0;
    if (u < n) begin
      a = u;
    end else if (u < 2 * n) begin
      a = 2 * n - u;
    end else if (u < 3 * n) begin
      a   = u - 2 * n;
      neg = 1'b1;
    end else begin
      a   = 4 * n - u;
      neg = 1'b1;
    end
    x  = a * HALF_PI_Q30 / 64'(SINE_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return neg ? 16'(64'd0 - q) : q[15:0];
  endfunction

  logic signed [15:0] tab [SINE_DEPTH];

  for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_tab
    assign tab[k] = sine_entry(k);
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

@@ rtl/led_effect_sequencer.sv @@
// Top level of the LED effect sequencer: state, sequencer and datapath.
// Depends on led_eff_pkg, led_eff_div and led_eff_sine.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | mode, now_ms, octave, period_ms, repeats,...
//  out     | out_valid / out_stall| led_0 .. led_4
//  cfg     | cfg_valid / cfg_ready| cfg_index (register), cfg_data
//
// Commands other than a tick are applied on acceptance; the two that return
// LED values (calibration entry, static in calibration) go on to S_EMIT.
// A tick uses no divider for bargraph and plain backgrounds, one pass of the
// shared 32-step divider for blink, validation, chase and wipe, and for breathe
// and crossfade up to two passes, a ROM read and one or two multiplies.
// Reset is synchronous; no clearing pass. A waiting result holds the output
// register while the block already accepts the next request.
module led_effect_sequencer
  import led_eff_pkg::*;
#(
  parameter int SINE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic [31:0]        in_now_ms,
  input  logic signed [3:0]  in_octave,
  input  logic [15:0]        in_period_ms,
  input  logic [7:0]         in_repeats,
  input  logic [7:0]         in_percent,
  input  logic [4:0]         in_pattern,
  input  logic               in_blink,
  input  logic [7:0]         in_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_led_0,
  output logic [7:0]         out_led_1,
  output logic [7:0]         out_led_2,
  output logic [7:0]         out_led_3,
  output logic [7:0]         out_led_4,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int SINE_AW = $clog2(SINE_DEPTH);

  seq_state_t state_r, state_nxt;

  // configuration
  logic [15:0] min_visible_r, min_visible_nxt;
  logic [15:0] bar_expiry_r, bar_expiry_nxt;
  logic [15:0] bar_render_r, bar_render_nxt;
  logic [15:0] blink_period_r, blink_period_nxt;
  logic [7:0]  breathe_floor_r, breathe_floor_nxt;

  // engine state
  logic        cal_r, cal_nxt;
  bg_kind_t    bg_kind_r, bg_kind_nxt;
  fx_t         active_r, active_nxt;
  fx_t         pending_r, pending_nxt;
  logic [15:0] pend_period_r, pend_period_nxt;
  logic [7:0]  pend_repeats_r, pend_repeats_nxt;
  logic [6:0]  pend_percent_r, pend_percent_nxt;
  logic [15:0] eff_period_r, eff_period_nxt;
  logic [7:0]  eff_repeats_r, eff_repeats_nxt;
  logic [6:0]  bar_percent_r, bar_percent_nxt;
  logic [31:0] eff_start_r, eff_start_nxt;
  logic [31:0] visible_until_r, visible_until_nxt;
  logic [31:0] bar_last_update_r, bar_last_update_nxt;
  logic [31:0] bar_last_render_r, bar_last_render_nxt;
  logic [2:0]  octave_led_r, octave_led_nxt;
  logic [15:0] breathe_period_r, breathe_period_nxt;
  logic [4:0]  static_pattern_r, static_pattern_nxt;
  logic        static_blink_r, static_blink_nxt;
  logic [7:0]  static_level_r, static_level_nxt;
  logic [31:0] bg_start_r, bg_start_nxt;
  logic        out_valid_r, out_valid_nxt;

  // per-request work registers
  logic [31:0]        now_r, now_nxt;
  job_t               job_r, job_nxt;
  logic [15:0]        per_r, per_nxt;
  logic [SINE_AW-1:0] addr_r, addr_nxt;
  logic [31:0]        prod_r, prod_nxt;
  led_vec_t           leds_r, leds_nxt;
  led_vec_t           out_led_r, out_led_nxt;

  // shared divider
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quot;
  logic [15:0] div_rem;

  logic signed [15:0] sine_q;
  logic [15:0]        wave_h;

  logic        in_acc;
  logic        cfg_acc;
  logic [31:0] el_fx;
  logic [31:0] el_bg;
  logic [23:0] rep_span;
  logic [31:0] fx_limit;
  logic        fx_timed_done;
  logic        pend_is_bar;
  logic        act_is_bar;
  logic        start_fx;
  logic        bar_expired;
  logic        bar_hold;
  logic [6:0]  bar_pct;
  logic [2:0]  inv_off;
  logic signed [4:0] oct_s;
  logic [2:0]  oct_led;
  logic [6:0]  pct_sat;
  logic [2:0]  chase_s;
  logic [2:0]  chase_idx;
  logic [9:0]  wipe_q;
  logic [19:0] wipe_w;
  logic [9:0]  wipe_third;
  logic [1:0]  wipe_s;
  logic [15:0] mul_b;
  logic [7:0]  span;
  logic [39:0] prod2;
  logic [7:0]  fade_a;

  led_eff_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  led_eff_sine #(.SINE_DEPTH(SINE_DEPTH)) u_sine (
    .clk  (clk),
    .addr (addr_r),
    .data (sine_q)
  );

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_led_0 = out_led_r[0];
  assign out_led_1 = out_led_r[1];
  assign out_led_2 = out_led_r[2];
  assign out_led_3 = out_led_r[3];
  assign out_led_4 = out_led_r[4];

  // command decode helpers
  assign oct_s   = $signed({in_octave[3], in_octave}) + 5'sd2;
  assign oct_led = (oct_s < 5'sd0) ? 3'd0 :
                   (oct_s > 5'sd4) ? 3'd4 : oct_s[2:0];
  assign pct_sat = (in_percent > 8'(PCT_MAX)) ? PCT_MAX : in_percent[6:0];

  // tick decisions
  assign el_fx    = now_r - eff_start_r;
  assign el_bg    = now_r - bg_start_r;
  assign rep_span = 24'(eff_repeats_r) * 24'(eff_period_r);

  always_comb begin
    case (active_r)
      FX_VALID, FX_XFADE: fx_limit = 32'(rep_span);
      FX_CHASE:           fx_limit = {5'd0, rep_span, 3'd0};
      FX_WIPE:            fx_limit = {7'd0, rep_span, 1'b0} + 32'(rep_span);
      default:            fx_limit = '0;
    endcase
  end

  assign fx_timed_done = el_fx >= fx_limit;
  assign pend_is_bar   = (pending_r == FX_BAR) || (pending_r == FX_INVBAR);
  assign act_is_bar    = (active_r == FX_BAR) || (active_r == FX_INVBAR);
  assign start_fx      = (pending_r != FX_NONE) && !(pend_is_bar && act_is_bar) &&
                         (now_r >= visible_until_r);
  assign bar_expired   = (now_r - bar_last_update_r) > 32'(bar_expiry_r);
  assign bar_hold      = (now_r - bar_last_render_r) < 32'(bar_render_r);
  assign bar_pct       = pend_is_bar ? pend_percent_r : bar_percent_r;
  assign inv_off       = (bar_pct >= 7'd80) ? 3'd4 :
                         (bar_pct >= 7'd60) ? 3'd3 :
                         (bar_pct >= 7'd40) ? 3'd2 :
                         (bar_pct >= 7'd20) ? 3'd1 : 3'd0;

  // chase bounces over eight steps; wipe step is quotient mod three
  assign chase_s    = div_quot[2:0];
  assign chase_idx  = (chase_s < 3'd5) ? chase_s : 3'(4'd8 - 4'(chase_s));
  assign wipe_q     = div_quot[9:0];
  assign wipe_w     = 20'(wipe_q) * 20'd683;
  assign wipe_third = 10'(wipe_w >> 11);
  assign wipe_s     = 2'(wipe_q - wipe_third * 10'd3);

  assign wave_h = sine_q ^ 16'sh8000;
  assign mul_b  = (job_r == JOB_BREATHE) ? wave_h : 16'(LEVEL_FULL);
  assign span   = LEVEL_FULL - breathe_floor_r;
  assign prod2  = 40'(prod_r) * 40'(span);
  assign fade_a = prod_r[23:16];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (mode_t'(in_mode))
            MODE_TICK:      state_nxt = S_START;
            MODE_CAL_ENTER: state_nxt = S_EMIT;
            MODE_STATIC:    state_nxt = cal_r ? S_EMIT : S_IDLE;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_START: state_nxt = S_EVAL;
      S_EVAL: begin
        case (active_r)
          FX_VALID, FX_CHASE, FX_XFADE, FX_WIPE:
            state_nxt = fx_timed_done ? S_BG : S_DIV1;
          FX_BAR, FX_INVBAR:
            state_nxt = bar_expired ? S_BG : (bar_hold ? S_IDLE : S_EMIT);
          default: state_nxt = S_BG;
        endcase
      end
      S_BG: begin
        case (bg_kind_r)
          BG_BREATHE: state_nxt = (breathe_period_r == 16'd0) ? S_SINE : S_DIV1;
          BG_STATIC:  state_nxt = (static_blink_r && blink_period_r != 16'd0) ? S_DIV1
                                                                             : S_EMIT;
          default:    state_nxt = S_EMIT;
        endcase
      end
      S_DIV1: begin
        if (div_done) begin
          state_nxt = (job_r == JOB_BREATHE || job_r == JOB_XFADE) ? S_DIV2 : S_EMIT;
        end
      end
      S_DIV2: if (div_done) state_nxt = S_SINE;
      S_SINE: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    min_visible_nxt     = min_visible_r;
    bar_expiry_nxt      = bar_expiry_r;
    bar_render_nxt      = bar_render_r;
    blink_period_nxt    = blink_period_r;
    breathe_floor_nxt   = breathe_floor_r;
    cal_nxt             = cal_r;
    bg_kind_nxt         = bg_kind_r;
    active_nxt          = active_r;
    pending_nxt         = pending_r;
    pend_period_nxt     = pend_period_r;
    pend_repeats_nxt    = pend_repeats_r;
    pend_percent_nxt    = pend_percent_r;
    eff_period_nxt      = eff_period_r;
    eff_repeats_nxt     = eff_repeats_r;
    bar_percent_nxt     = bar_percent_r;
    eff_start_nxt       = eff_start_r;
    visible_until_nxt   = visible_until_r;
    bar_last_update_nxt = bar_last_update_r;
    bar_last_render_nxt = bar_last_render_r;
    octave_led_nxt      = octave_led_r;
    breathe_period_nxt  = breathe_period_r;
    static_pattern_nxt  = static_pattern_r;
    static_blink_nxt    = static_blink_r;
    static_level_nxt    = static_level_r;
    bg_start_nxt        = bg_start_r;
    now_nxt             = now_r;
    job_nxt             = job_r;
    per_nxt             = per_r;
    addr_nxt            = addr_r;
    prod_nxt            = prod_r;
    leds_nxt            = leds_r;
    out_led_nxt         = out_led_r;
    out_valid_nxt       = out_valid_r && out_stall;
    div_start           = 1'b0;
    div_dividend        = el_fx;
    div_divisor         = eff_period_r;

    if (cfg_acc) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_VISIBLE:   min_visible_nxt   = cfg_data;
        CFG_BAR_EXPIRY:    bar_expiry_nxt    = cfg_data;
        CFG_BAR_RENDER:    bar_render_nxt    = cfg_data;
        CFG_BLINK_PERIOD:  blink_period_nxt  = cfg_data;
        CFG_BREATHE_FLOOR: breathe_floor_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt = in_now_ms;
          case (mode_t'(in_mode))
            MODE_OCTAVE: begin
              if (!cal_r) begin
                bg_kind_nxt        = BG_BREATHE;
                octave_led_nxt     = oct_led;
                breathe_period_nxt = in_period_ms;
                bg_start_nxt       = in_now_ms;
              end
            end
            MODE_BAR, MODE_INVBAR: begin
              if (!cal_r) begin
                pending_nxt      = (mode_t'(in_mode) == MODE_BAR) ? FX_BAR : FX_INVBAR;
                pend_percent_nxt = pct_sat;
              end
            end
            MODE_STATIC: begin
              if (cal_r) begin
                for (int i = 0; i < LED_COUNT; i++) begin
                  leds_nxt[i] = in_pattern[i] ? in_level : 8'd0;
                end
              end else begin
                bg_kind_nxt        = BG_STATIC;
                static_pattern_nxt = in_pattern;
                static_blink_nxt   = in_blink;
                static_level_nxt   = in_level;
                bg_start_nxt       = in_now_ms;
              end
            end
            MODE_VALID, MODE_CHASE, MODE_XFADE, MODE_WIPE: begin
              case (mode_t'(in_mode))
                MODE_VALID: pending_nxt = FX_VALID;
                MODE_CHASE: pending_nxt = FX_CHASE;
                MODE_XFADE: pending_nxt = FX_XFADE;
                default:    pending_nxt = FX_WIPE;
              endcase
              pend_period_nxt  = in_period_ms;
              pend_repeats_nxt = in_repeats;
            end
            MODE_CAL_ENTER: begin
              cal_nxt     = 1'b1;
              active_nxt  = FX_NONE;
              pending_nxt = FX_NONE;
              bg_kind_nxt = BG_NONE;
              leds_nxt    = '0;
            end
            MODE_CAL_EXIT: begin
              cal_nxt      = 1'b0;
              active_nxt   = FX_NONE;
              pending_nxt  = FX_NONE;
              bg_kind_nxt  = BG_BREATHE;
              bg_start_nxt = in_now_ms;
            end
            default: ;
          endcase
        end
      end

      S_START: begin
        if (start_fx) begin
          active_nxt        = pending_r;
          pending_nxt       = FX_NONE;
          eff_start_nxt     = now_r;
          visible_until_nxt = now_r + 32'(min_visible_r);
          eff_period_nxt    = pend_period_r;
          eff_repeats_nxt   = pend_repeats_r;
          if (pend_is_bar) begin
            bar_percent_nxt     = pend_percent_r;
            bar_last_update_nxt = now_r;
            bar_last_render_nxt = '0;
          end
        end
      end

      S_EVAL: begin
        case (active_r)
          FX_VALID, FX_CHASE, FX_XFADE, FX_WIPE: begin
            if (fx_timed_done) begin
              active_nxt = FX_NONE;
            end else begin
              div_start    = 1'b1;
              div_dividend = el_fx;
              div_divisor  = eff_period_r;
              per_nxt      = eff_period_r;
              case (active_r)
                FX_VALID: job_nxt = JOB_VALID;
                FX_CHASE: job_nxt = JOB_CHASE;
                FX_XFADE: job_nxt = JOB_XFADE;
                default:  job_nxt = JOB_WIPE;
              endcase
            end
          end
          FX_BAR, FX_INVBAR: begin
            if (bar_expired) begin
              active_nxt = FX_NONE;
            end else begin
              // refresh in place
              if (pend_is_bar) begin
                bar_percent_nxt     = pend_percent_r;
                bar_last_update_nxt = now_r;
                pending_nxt         = FX_NONE;
              end
              if (!bar_hold) begin
                bar_last_render_nxt = now_r;
                for (int i = 0; i < LED_COUNT; i++) begin
                  if (active_r == FX_BAR) begin
                    leds_nxt[i] = bar_led(bar_pct, 3'(i));
                  end else begin
                    leds_nxt[i] = (inv_off == 3'(i)) ? 8'd0 : LEVEL_FULL;
                  end
                end
              end
            end
          end
          default: active_nxt = FX_NONE;
        endcase
      end

      S_BG: begin
        leds_nxt     = '0;
        div_dividend = el_bg;
        case (bg_kind_r)
          BG_BREATHE: begin
            job_nxt = JOB_BREATHE;
            if (breathe_period_r == 16'd0) begin
              addr_nxt = '0;
            end else begin
              div_start   = 1'b1;
              div_divisor = breathe_period_r;
              per_nxt     = breathe_period_r;
            end
          end
          BG_STATIC: begin
            if (!static_blink_r) begin
              for (int i = 0; i < LED_COUNT; i++) begin
                leds_nxt[i] = static_pattern_r[i] ? static_level_r : 8'd0;
              end
            end else if (blink_period_r != 16'd0) begin
              job_nxt     = JOB_BLINK;
              div_start   = 1'b1;
              div_divisor = blink_period_r;
              per_nxt     = blink_period_r;
            end
          end
          default: ;
        endcase
      end

      S_DIV1: begin
        if (div_done) begin
          leds_nxt = '0;
          case (job_r)
            JOB_VALID: begin
              if (div_rem < (per_r >> 1)) begin
                leds_nxt[1] = LEVEL_FULL;
                leds_nxt[2] = LEVEL_FULL;
                leds_nxt[3] = LEVEL_FULL;
              end
            end
            JOB_CHASE: leds_nxt[chase_idx] = LEVEL_FULL;
            JOB_WIPE: begin
              case (wipe_s)
                2'd0: begin
                  leds_nxt[0] = LEVEL_FULL;
                  leds_nxt[4] = LEVEL_FULL;
                end
                2'd1: begin
                  leds_nxt[1] = LEVEL_FULL;
                  leds_nxt[3] = LEVEL_FULL;
                end
                default: leds_nxt[2] = LEVEL_FULL;
              endcase
            end
            JOB_BLINK: begin
              if (div_rem < (per_r >> 1)) begin
                for (int i = 0; i < LED_COUNT; i++) begin
                  leds_nxt[i] = static_pattern_r[i] ? static_level_r : 8'd0;
                end
              end
            end
            default: begin
              // phase = remainder * depth / period
              div_start    = 1'b1;
              div_dividend = 32'(div_rem) * 32'(SINE_DEPTH);
              div_divisor  = per_r;
            end
          endcase
        end
      end

      S_DIV2: if (div_done) addr_nxt = div_quot[SINE_AW-1:0];

      S_MUL1: prod_nxt = 32'(wave_h) * 32'(mul_b);

      S_MUL2: begin
        leds_nxt = '0;
        if (job_r == JOB_BREATHE) begin
          leds_nxt[octave_led_r] = breathe_floor_r + prod2[39:32];
        end else begin
          leds_nxt[0] = fade_a;
          leds_nxt[4] = LEVEL_FULL - fade_a;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_led_nxt   = leds_r;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      min_visible_r     <= MIN_VISIBLE_RST;
      bar_expiry_r      <= BAR_EXPIRY_RST;
      bar_render_r      <= BAR_RENDER_RST;
      blink_period_r    <= BLINK_PERIOD_RST;
      breathe_floor_r   <= '0;
      cal_r             <= 1'b0;
      bg_kind_r         <= BG_BREATHE;
      active_r          <= FX_NONE;
      pending_r         <= FX_NONE;
      pend_period_r     <= '0;
      pend_repeats_r    <= '0;
      pend_percent_r    <= '0;
      eff_period_r      <= '0;
      eff_repeats_r     <= '0;
      bar_percent_r     <= '0;
      eff_start_r       <= '0;
      visible_until_r   <= '0;
      bar_last_update_r <= '0;
      bar_last_render_r <= '0;
      octave_led_r      <= OCTAVE_LED_RST;
      breathe_period_r  <= BREATHE_PERIOD_RST;
      static_pattern_r  <= '0;
      static_blink_r    <= 1'b0;
      static_level_r    <= LEVEL_FULL;
      bg_start_r        <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      min_visible_r     <= min_visible_nxt;
      bar_expiry_r      <= bar_expiry_nxt;
      bar_render_r      <= bar_render_nxt;
      blink_period_r    <= blink_period_nxt;
      breathe_floor_r   <= breathe_floor_nxt;
      cal_r             <= cal_nxt;
      bg_kind_r         <= bg_kind_nxt;
      active_r          <= active_nxt;
      pending_r         <= pending_nxt;
      pend_period_r     <= pend_period_nxt;
      pend_repeats_r    <= pend_repeats_nxt;
      pend_percent_r    <= pend_percent_nxt;
      eff_period_r      <= eff_period_nxt;
      eff_repeats_r     <= eff_repeats_nxt;
      bar_percent_r     <= bar_percent_nxt;
      eff_start_r       <= eff_start_nxt;
      visible_until_r   <= visible_until_nxt;
      bar_last_update_r <= bar_last_update_nxt;
      bar_last_render_r <= bar_last_render_nxt;
      octave_led_r      <= octave_led_nxt;
      breathe_period_r  <= breathe_period_nxt;
      static_pattern_r  <= static_pattern_nxt;
      static_blink_r    <= static_blink_nxt;
      static_level_r    <= static_level_nxt;
      bg_start_r        <= bg_start_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    job_r     <= job_nxt;
    per_r     <= per_nxt;
    addr_r    <= addr_nxt;
    prod_r    <= prod_nxt;
    leds_r    <= leds_nxt;
    out_led_r <= out_led_nxt;
  end

endmodule

@@ rtl/led_eff_chk.sv @@
// Port-level checker for the LED effect sequencer, bound to the top level.
// Depends on led_eff_pkg for the mode codes.
module led_eff_chk
  import led_eff_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [3:0]  in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_led_0,
  input logic [7:0]  out_led_4
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_0) && $stable(out_led_4))
    else $error("stalled result changed");

  // a tick always starts work, so the input side stalls next
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode == MODE_TICK |=> in_stall)
    else $error("tick did not start the sequencer");

  // entering calibration goes on to emit a result, so the input side stalls
  a_cal_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode == MODE_CAL_ENTER |=> in_stall)
    else $error("calibration entry gave no result");

  // a new result only comes out of work in progress
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind led_effect_sequencer led_eff_chk u_led_eff_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_led_0 (out_led_0),
  .out_led_4 (out_led_4)
);
